@@ hw/rtl/ufhg_pkg.sv @@
`default_nettype none
package ufhg_pkg;

  // Output framing
  localparam int unsigned HalfwordCount = 23;
  localparam int unsigned IndexWidth    = 5;
  localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(HalfwordCount - 1);

  // Field widths
  localparam int unsigned LenWidth  = 11;
  localparam int unsigned MacWidth  = 48;
  localparam int unsigned IpWidth   = 32;
  localparam int unsigned PortWidth = 16;
  localparam int unsigned SeqWidth  = 32;
  localparam int unsigned HwWidth   = 16;
  localparam int unsigned SumWidth  = 19;

  // Fixed header words
  localparam logic [HwWidth-1:0] EthTypeIpv4 = 16'h0800;
  localparam logic [HwWidth-1:0] IpVerIhlTos = 16'h4500;
  localparam logic [HwWidth-1:0] IpTtlProto  = 16'h4011;
  localparam logic [HwWidth-1:0] EthHdrBytes = 16'd14;
  localparam logic [HwWidth-1:0] IpHdrBytes  = 16'd20;

  // Configuration port
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = MacWidth;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_DEST_MAC    = 3'd0,
    CFG_SOURCE_MAC  = 3'd1,
    CFG_SOURCE_IP   = 3'd2,
    CFG_DEST_IP     = 3'd3,
    CFG_SOURCE_PORT = 3'd4,
    CFG_DEST_PORT   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [MacWidth-1:0]  dest_mac;
    logic [MacWidth-1:0]  source_mac;
    logic [IpWidth-1:0]   source_ip;
    logic [IpWidth-1:0]   dest_ip;
    logic [PortWidth-1:0] source_port;
    logic [PortWidth-1:0] dest_port;
  } cfg_t;

  // Per-frame values held while its halfwords stream out
  typedef struct packed {
    logic [HwWidth-1:0]  ip_len;
    logic [HwWidth-1:0]  udp_len;
    logic [SumWidth-1:0] csum_sum;
    logic [SeqWidth-1:0] seq;
  } item_t;

endpackage
`default_nettype wire

@@ hw/rtl/ufhg_if.sv @@
`default_nettype none
interface ufhg_req_if;
  import ufhg_pkg::*;

  logic                valid;
  logic                ready;
  logic [LenWidth-1:0] frame_length;

  modport source (output valid, output frame_length, input ready);
  modport sink (input valid, input frame_length, output ready);
endinterface

interface ufhg_hw_if;
  import ufhg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [HwWidth-1:0]    frame_halfword;
  logic [IndexWidth-1:0] halfword_index;
  logic                  last;

  modport source (output valid, output frame_halfword, output halfword_index,
                  output last, input ready);
  modport sink (input valid, input frame_halfword, input halfword_index,
                input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ufhg_field_mux.sv @@
`default_nettype none
module ufhg_field_mux (
  input  ufhg_pkg::cfg_t                   cfg,
  input  ufhg_pkg::item_t                  item,
  input  logic [ufhg_pkg::IndexWidth-1:0]  idx,
  output logic [ufhg_pkg::HwWidth-1:0]     halfword
);
  import ufhg_pkg::*;

  logic [HwWidth:0]   fold1;
  logic [HwWidth:0]   fold2;
  logic [HwWidth-1:0] csum;

  // Fold the header sum twice, then invert
  always_comb begin
    fold1 = (HwWidth+1)'(item.csum_sum[HwWidth-1:0])
          + (HwWidth+1)'(item.csum_sum[SumWidth-1:HwWidth]);
    fold2 = (HwWidth+1)'(fold1[HwWidth-1:0]) + (HwWidth+1)'(fold1[HwWidth]);
    csum  = ~fold2[HwWidth-1:0];
  end

  // Select the halfword for this position
  always_comb begin
    case (idx)
      5'd0:    halfword = cfg.dest_mac[47:32];
      5'd1:    halfword = cfg.dest_mac[31:16];
      5'd2:    halfword = cfg.dest_mac[15:0];
      5'd3:    halfword = cfg.source_mac[47:32];
      5'd4:    halfword = cfg.source_mac[31:16];
      5'd5:    halfword = cfg.source_mac[15:0];
      5'd6:    halfword = EthTypeIpv4;
      5'd7:    halfword = IpVerIhlTos;
      5'd8:    halfword = item.ip_len;
      5'd11:   halfword = IpTtlProto;
      5'd12:   halfword = csum;
      5'd13:   halfword = cfg.source_ip[31:16];
      5'd14:   halfword = cfg.source_ip[15:0];
      5'd15:   halfword = cfg.dest_ip[31:16];
      5'd16:   halfword = cfg.dest_ip[15:0];
      5'd17:   halfword = cfg.source_port;
      5'd18:   halfword = cfg.dest_port;
      5'd19:   halfword = item.udp_len;
      5'd21:   halfword = item.seq[31:16];
      5'd22:   halfword = item.seq[15:0];
      default: halfword = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/udp_frame_header_generator_unit.sv @@
`default_nettype none
// Ethernet/IPv4/UDP header generator. Each request on req carries a frame
// length; the block answers with 23 big-endian halfwords on rsp (Ethernet
// header, IPv4 header with its checksum, UDP header with checksum zero, then
// a 32-bit sequence number that counts requests from zero and wraps), with
// halfword_index 0..22 and last set on the final one. One halfword leaves per
// cycle unless rsp.ready stalls it; a one-entry request buffer takes the next
// request while the current header streams, so back-to-back requests give a
// gapless halfword stream. A request reaches rsp via the request buffer, the
// active-frame and output registers. Configuration registers (addresses,
// ports) reset to zero; the user must write them via cfg_we/cfg_index/cfg_wdata
// only while no request is in flight; the block itself does not enforce this.
module udp_frame_header_generator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ufhg_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [ufhg_pkg::CfgDataWidth-1:0]   cfg_wdata,
  ufhg_req_if.sink                            req,
  ufhg_hw_if.source                           rsp
);
  import ufhg_pkg::*;

  cfg_t                  cfg;
  logic [SeqWidth-1:0]   seq;

  logic                  buf_valid;
  logic [LenWidth-1:0]   buf_len;
  logic [SeqWidth-1:0]   buf_seq;

  logic                  act_valid;
  item_t                 act;
  item_t                 act_next;
  logic [IndexWidth-1:0] idx;

  logic                  out_valid;
  logic [HwWidth-1:0]    out_hw;
  logic [IndexWidth-1:0] out_idx;
  logic                  out_last;

  logic                  req_xfer;
  logic                  emit_fire;
  logic                  act_done;
  logic                  load;
  logic [HwWidth-1:0]    halfword;

  assign req.ready = !buf_valid;
  assign req_xfer  = req.valid && req.ready;
  assign emit_fire = act_valid && (!out_valid || rsp.ready);
  assign act_done  = emit_fire && (idx == LastIndex);
  assign load      = buf_valid && (!act_valid || act_done);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEST_MAC:    cfg.dest_mac    <= cfg_wdata[MacWidth-1:0];
        CFG_SOURCE_MAC:  cfg.source_mac  <= cfg_wdata[MacWidth-1:0];
        CFG_SOURCE_IP:   cfg.source_ip   <= cfg_wdata[IpWidth-1:0];
        CFG_DEST_IP:     cfg.dest_ip     <= cfg_wdata[IpWidth-1:0];
        CFG_SOURCE_PORT: cfg.source_port <= cfg_wdata[PortWidth-1:0];
        CFG_DEST_PORT:   cfg.dest_port   <= cfg_wdata[PortWidth-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request and its sequence number
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      seq       <= '0;
    end else begin
      if (req_xfer) begin
        buf_valid <= 1'b1;
        seq       <= seq + SeqWidth'(1);
      end else if (load) begin
        buf_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      buf_len <= req.frame_length;
      buf_seq <= seq;
    end
  end

  // Derive lengths and the raw header sum for the next frame
  always_comb begin
    act_next.ip_len   = HwWidth'(buf_len) - EthHdrBytes;
    act_next.udp_len  = act_next.ip_len - IpHdrBytes;
    act_next.seq      = buf_seq;
    act_next.csum_sum = SumWidth'(IpVerIhlTos) + SumWidth'(IpTtlProto)
                      + SumWidth'(act_next.ip_len)
                      + SumWidth'(cfg.source_ip[31:16]) + SumWidth'(cfg.source_ip[15:0])
                      + SumWidth'(cfg.dest_ip[31:16]) + SumWidth'(cfg.dest_ip[15:0]);
  end

  // Advance through the halfwords of the active frame
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      act_valid <= 1'b1;
      idx       <= '0;
    end else if (act_done) begin
      act_valid <= 1'b0;
    end else if (emit_fire) begin
      idx       <= idx + IndexWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act <= act_next;
    end
  end

  ufhg_field_mux u_field_mux (
    .cfg      (cfg),
    .item     (act),
    .idx      (idx),
    .halfword (halfword)
  );

  // Output register; drop valid once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_hw   <= halfword;
      out_idx  <= idx;
      out_last <= (idx == LastIndex);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.frame_halfword = out_hw;
  assign rsp.halfword_index = out_idx;
  assign rsp.last           = out_last;

  // Checks
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> (idx <= LastIndex))
    else $error("halfword index past end of header");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    act_done |=> (rsp.valid && rsp.last && (rsp.halfword_index == LastIndex)))
    else $error("final halfword not presented with last");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> (act_valid && (idx == '0) && !buf_valid))
    else $error("frame load did not restart at halfword zero");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> (seq == $past(seq) + SeqWidth'(1)) && (buf_seq == $past(seq)))
    else $error("sequence number not advanced on request transfer");

endmodule
`default_nettype wire

@@ bench/tb_udp_frame_header_generator_unit.sv @@
`timescale 1ns / 1ps
module tb_udp_frame_header_generator_unit;
  import ufhg_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned MaxGap       = 6;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldOffCycles = 120;
  localparam int unsigned MaxPrinted   = 30;
  localparam logic [CfgIndexWidth-1:0] CfgIndexSpareLo = 3'd6;
  localparam logic [CfgIndexWidth-1:0] CfgIndexSpareHi = 3'd7;
  localparam logic [LenWidth-1:0] LenMin  = 11'd46;
  localparam logic [LenWidth-1:0] LenMax  = 11'd1514;
  localparam logic [LenWidth-1:0] LenFull = 11'h7ff;

  typedef struct {
    logic [HwWidth-1:0]    halfword;
    logic [IndexWidth-1:0] index;
    logic                  last;
  } halfword_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_wdata;

  ufhg_req_if req_ch();
  ufhg_hw_if  hw_ch();

  udp_frame_header_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (hw_ch)
  );

  // Shadow copy of the block's registers and frame counter
  cfg_t                cfg_shadow;
  logic [SeqWidth-1:0] seq_shadow;
  halfword_t           pending_halfwords[$];

  int error_count       = 0;
  int frames_sent       = 0;
  int halfwords_checked = 0;
  int settings_used     = 0;
  int cycle_count       = 0;
  bit gaps_on           = 1'b1;
  int rx_hold_req       = 0;

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Build the 23 expected halfwords of one header and advance the frame counter
  function automatic void predict_header(input logic [LenWidth-1:0] flen);
    logic [HwWidth-1:0] hw [HalfwordCount];
    logic [HwWidth-1:0] ip_len;
    logic [HwWidth-1:0] udp_len;
    logic [31:0]        sum;
    halfword_t          entry;
    ip_len  = {5'd0, flen} - EthHdrBytes;
    udp_len = ip_len - IpHdrBytes;
    hw[0]  = cfg_shadow.dest_mac[47:32];
    hw[1]  = cfg_shadow.dest_mac[31:16];
    hw[2]  = cfg_shadow.dest_mac[15:0];
    hw[3]  = cfg_shadow.source_mac[47:32];
    hw[4]  = cfg_shadow.source_mac[31:16];
    hw[5]  = cfg_shadow.source_mac[15:0];
    hw[6]  = EthTypeIpv4;
    hw[7]  = IpVerIhlTos;
    hw[8]  = ip_len;
    hw[9]  = '0;
    hw[10] = '0;
    hw[11] = IpTtlProto;
    hw[12] = '0;
    hw[13] = cfg_shadow.source_ip[31:16];
    hw[14] = cfg_shadow.source_ip[15:0];
    hw[15] = cfg_shadow.dest_ip[31:16];
    hw[16] = cfg_shadow.dest_ip[15:0];
    hw[17] = cfg_shadow.source_port;
    hw[18] = cfg_shadow.dest_port;
    hw[19] = udp_len;
    hw[20] = '0;
    hw[21] = seq_shadow[31:16];
    hw[22] = seq_shadow[15:0];
    // Ones'-complement sum over the IP header, checksum word as zero
    sum = '0;
    for (int i = 7; i <= 16; i++) begin
      sum = sum + {16'd0, hw[i]};
    end
    sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
    sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
    hw[12] = ~sum[15:0];
    for (int i = 0; i < HalfwordCount; i++) begin
      entry.halfword = hw[i];
      entry.index    = IndexWidth'(i);
      entry.last     = (i == HalfwordCount - 1);
      pending_halfwords.push_back(entry);
    end
    seq_shadow = seq_shadow + 1'b1;
  endfunction

  // Compare each halfword transfer with the oldest expectation
  always @(posedge clk) begin : check_halfwords
    halfword_t want;
    if (!rst && hw_ch.valid === 1'b1 && hw_ch.ready === 1'b1) begin
      if (pending_halfwords.size() == 0) begin
        report_mismatch($sformatf("unexpected halfword %h index %0d",
                                  hw_ch.frame_halfword, hw_ch.halfword_index));
      end else begin
        want = pending_halfwords.pop_front();
        halfwords_checked++;
        if (hw_ch.frame_halfword !== want.halfword) begin
          report_mismatch($sformatf("halfword %0d: got %h, expected %h",
                                    want.index, hw_ch.frame_halfword, want.halfword));
        end
        if (hw_ch.halfword_index !== want.index) begin
          report_mismatch($sformatf("index: got %0d, expected %0d",
                                    hw_ch.halfword_index, want.index));
        end
        if (hw_ch.last !== want.last) begin
          report_mismatch($sformatf("halfword %0d: last got %b, expected %b",
                                    want.index, hw_ch.last, want.last));
        end
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d halfwords still expected",
               cycle_count, pending_halfwords.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Drive ready: random stall per transfer, plus a long hold-off on request
  initial begin : drive_ready
    int stall;
    hw_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        hw_ch.ready <= 1'b0;
        repeat (rx_hold_req) @(negedge clk);
        rx_hold_req = 0;
      end
      stall = gaps_on ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        hw_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      hw_ch.ready <= 1'b1;
      @(posedge clk);
      while (hw_ch.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one request; valid stays high on return so the next one can follow
  task automatic send_frame(input logic [LenWidth-1:0] flen);
    int gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.frame_length <= flen;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predict_header(flen);
    frames_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every header has come out
  task automatic drain_frames();
    req_ch.valid <= 1'b0;
    while (pending_halfwords.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0]  data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DEST_MAC:    cfg_shadow.dest_mac    = data[MacWidth-1:0];
      CFG_SOURCE_MAC:  cfg_shadow.source_mac  = data[MacWidth-1:0];
      CFG_SOURCE_IP:   cfg_shadow.source_ip   = data[IpWidth-1:0];
      CFG_DEST_IP:     cfg_shadow.dest_ip     = data[IpWidth-1:0];
      CFG_SOURCE_PORT: cfg_shadow.source_port = data[PortWidth-1:0];
      CFG_DEST_PORT:   cfg_shadow.dest_port   = data[PortWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(CFG_DEST_MAC,    CfgDataWidth'(c.dest_mac));
    write_reg(CFG_SOURCE_MAC,  CfgDataWidth'(c.source_mac));
    write_reg(CFG_SOURCE_IP,   CfgDataWidth'(c.source_ip));
    write_reg(CFG_DEST_IP,     CfgDataWidth'(c.dest_ip));
    write_reg(CFG_SOURCE_PORT, CfgDataWidth'(c.source_port));
    write_reg(CFG_DEST_PORT,   CfgDataWidth'(c.dest_port));
    settings_used++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.dest_mac    = MacWidth'({$urandom, $urandom});
    c.source_mac  = MacWidth'({$urandom, $urandom});
    c.source_ip   = $urandom;
    c.dest_ip     = $urandom;
    c.source_port = PortWidth'($urandom);
    c.dest_port   = PortWidth'($urandom);
    return c;
  endfunction

  // Mostly legal frame sizes, some anywhere in the field's range
  function automatic logic [LenWidth-1:0] pick_length();
    if ($urandom_range(0, 4) == 0) begin
      return LenWidth'($urandom_range(0, LenFull));
    end
    return LenWidth'($urandom_range(LenMin, LenMax));
  endfunction

  task automatic test_reset_defaults();
    gaps_on = 1'b1;
    send_frame(LenMin);
    send_frame(LenMax);
    drain_frames();
  endtask

  task automatic test_length_extremes();
    cfg_t c;
    c = '1;
    load_settings(c);
    send_frame(11'd0);
    send_frame(11'd13);
    send_frame(11'd14);
    send_frame(11'd33);
    send_frame(11'd34);
    send_frame(LenFull);
    drain_frames();
    // Alternating bit patterns in every field
    c = {(MacWidth * 2 + IpWidth * 2 + PortWidth * 2) / 2{2'b10}};
    load_settings(c);
    send_frame(11'h555);
    send_frame(LenMin);
    send_frame(11'd1515);
    drain_frames();
    c = ~c;
    load_settings(c);
    send_frame(11'h2aa);
    send_frame(LenMax);
    send_frame(11'd1);
    drain_frames();
  endtask

  // Writes to the spare indexes must leave every register alone
  task automatic test_spare_index();
    write_reg(CfgIndexSpareLo, '1);
    write_reg(CfgIndexSpareHi, '0);
    send_frame(pick_length());
    send_frame(pick_length());
    send_frame(pick_length());
    drain_frames();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    load_settings(random_settings());
    repeat (10) send_frame(pick_length());
    drain_frames();
    gaps_on = 1'b1;
  endtask

  // Hold off the output so the block fills and stalls its input
  task automatic test_receiver_holdoff();
    gaps_on = 1'b0;
    rx_hold_req = HoldOffCycles;
    repeat (8) send_frame(pick_length());
    drain_frames();
    gaps_on = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    gaps_on = 1'b1;
    repeat (4) begin
      repeat (3) send_frame(pick_length());
      drain_frames();
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_settings('0);
        1: load_settings('1);
        default: load_settings(random_settings());
      endcase
      gaps_on = (phase % 3 != 2);
      repeat (28) send_frame(pick_length());
      drain_frames();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.frame_length = '0;
    cfg_shadow          = '0;
    seq_shadow          = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_length_extremes();
    test_spare_index();
    test_back_to_back();
    test_receiver_holdoff();
    test_pause_until_drained();
    test_random_traffic();
    drain_frames();

    $display("ran %0d frames, %0d halfwords checked, %0d register settings",
             frames_sent, halfwords_checked, settings_used);
    $display("lengths 0..2047, spare index writes, gapless, output hold-off, drained pauses");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
